// ----- src/assert_macros.svh -----
// Assertion macros shared by the region average color unit.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rac_pkg.sv -----
// Shared types and constants of the region average color unit.
// Used by every module of the block; depends on nothing.
package rac_pkg;

    localparam int MAX_SCREEN_DIM_DEF = 4096;

    localparam int COORD_W   = 17;
    localparam int COLOR_W   = 8;
    localparam int SUM_W     = 32;
    localparam int COUNT_W   = 25;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 3;

    // Register levels in the region clipping pipeline.
    localparam int CLIP_STAGES = 5;
    // Frame results that may wait between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_TOP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd7;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic signed [13:0] capture_left;
        logic signed [13:0] capture_top;
        logic [12:0]        screen_width;
        logic [12:0]        screen_height;
        logic signed [13:0] region_x;
        logic signed [13:0] region_y;
        logic [12:0]        region_width;
        logic [12:0]        region_height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        capture_left:  14'sd0,
        capture_top:   14'sd0,
        screen_width:  13'd1920,
        screen_height: 13'd1080,
        region_x:      14'sd0,
        region_y:      14'sd0,
        region_width:  13'd64,
        region_height: 13'd64
    };

    // Clipped region in capture coordinates, half-open on the high side.
    typedef struct packed {
        coord_t x_lo;
        coord_t x_hi;
        coord_t y_lo;
        coord_t y_hi;
        coord_t screen_w;
        logic   ok;
        logic   settled;
    } clip_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum_red;
        logic [SUM_W-1:0]   sum_green;
        logic [SUM_W-1:0]   sum_blue;
        logic [COUNT_W-1:0] count;
        logic               ok;
    } frame_sum_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- src/region_average_color_unit.sv -----
// Channel  | handshake          | payload
// s_       | s_valid / s_ready  | s_pix_blue, s_pix_green, s_pix_red, s_frame_end
// m_       | m_valid / m_ready  | m_avg_red, m_avg_green, m_avg_blue, m_region_empty
// cfg_     | cfg_wr_en          | cfg_index, cfg_wr_data
//
// Pixels are taken one per cycle while s_ready is high; the sums are updated in the cycle of the transfer.
// A frame result is loaded from the queue into three restoring divider lanes that share
// one step counter, set by the 34-bit dividend, and is then held in the output state.
// Two finished frames can wait in the queue; the input stalls while it is full, and
// after reset and after each register write s_ready is low while the clipping pipeline
// settles. Reset is synchronous and active low.
//
// Top level of the region average color unit.
// Depends on rac_pkg, rac_clip, rac_front, rac_queue, rac_back and assert_macros.svh.
`include "assert_macros.svh"

module region_average_color_unit #(
    parameter int MAX_SCREEN_DIM = rac_pkg::MAX_SCREEN_DIM_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rac_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rac_pkg::COLOR_W-1:0]    s_pix_blue,
    input  logic [rac_pkg::COLOR_W-1:0]    s_pix_green,
    input  logic [rac_pkg::COLOR_W-1:0]    s_pix_red,
    input  logic                           s_frame_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rac_pkg::COLOR_W-1:0]    m_avg_red,
    output logic [rac_pkg::COLOR_W-1:0]    m_avg_green,
    output logic [rac_pkg::COLOR_W-1:0]    m_avg_blue,
    output logic                           m_region_empty
);

    rac_pkg::cfg_t          cfg_reg, cfg_next;
    rac_pkg::clip_t         clip;
    rac_pkg::queue_status_t q_status;
    rac_pkg::frame_sum_t    push_data, rd_data;
    logic                   push, pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rac_pkg::REG_CAPTURE_LEFT:  cfg_next.capture_left  = cfg_wr_data;
                rac_pkg::REG_CAPTURE_TOP:   cfg_next.capture_top   = cfg_wr_data;
                rac_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wr_data[12:0];
                rac_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wr_data[12:0];
                rac_pkg::REG_REGION_X:      cfg_next.region_x      = cfg_wr_data;
                rac_pkg::REG_REGION_Y:      cfg_next.region_y      = cfg_wr_data;
                rac_pkg::REG_REGION_WIDTH:  cfg_next.region_width  = cfg_wr_data[12:0];
                rac_pkg::REG_REGION_HEIGHT: cfg_next.region_height = cfg_wr_data[12:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= rac_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rac_clip #(
        .MAX_SCREEN_DIM(MAX_SCREEN_DIM)
    ) u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cfg_write (cfg_wr_en),
        .clip      (clip)
    );

    rac_front #(
        .MAX_SCREEN_DIM(MAX_SCREEN_DIM)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clip        (clip),
        .q_status    (q_status),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pix_blue  (s_pix_blue),
        .s_pix_green (s_pix_green),
        .s_pix_red   (s_pix_red),
        .s_frame_end (s_frame_end),
        .push        (push),
        .push_data   (push_data)
    );

    rac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_data   (rd_data),
        .status    (q_status)
    );

    rac_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_status       (q_status),
        .rd_data        (rd_data),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_avg_red      (m_avg_red),
        .m_avg_green    (m_avg_green),
        .m_avg_blue     (m_avg_blue),
        .m_region_empty (m_region_empty)
    );

    // A register write must hold off pixels until the clipped bounds settle.
    `ASSERT_NEXT(a_cfg_holds_input, aclk, aresetn, cfg_wr_en, !s_ready, "pixel taken before clip settled")

    // An empty region always reports black.
    `ASSERT_IMPLIES(a_empty_is_black, aclk, aresetn, m_valid && m_region_empty, (m_avg_red == '0) && (m_avg_green == '0) && (m_avg_blue == '0), "empty region not black")

    // A full queue must stall the input so no frame result is dropped.
    `ASSERT_IMPLIES(a_full_stalls_input, aclk, aresetn, q_status.full, !s_ready, "input ready while queue full")

endmodule

// ----- src/rac_clip.sv -----
// Region clipping pipeline: turns the configuration registers into
// capture-space bounds. Depends on rac_pkg.
module rac_clip #(
    parameter int MAX_SCREEN_DIM = rac_pkg::MAX_SCREEN_DIM_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  rac_pkg::cfg_t  cfg,
    input  logic           cfg_write,
    output rac_pkg::clip_t clip
);

    localparam int SETTLE_W = $clog2(rac_pkg::CLIP_STAGES + 1);

    function automatic rac_pkg::coord_t clamp_dim(input logic [12:0] v);
        if (v == '0) begin
            clamp_dim = rac_pkg::coord_t'(1);
        end else if (rac_pkg::coord_t'(v) > rac_pkg::coord_t'(MAX_SCREEN_DIM)) begin
            clamp_dim = rac_pkg::coord_t'(MAX_SCREEN_DIM);
        end else begin
            clamp_dim = rac_pkg::coord_t'(v);
        end
    endfunction

    rac_pkg::coord_t xd_reg, yd_reg, sw_reg, sh_reg;
    rac_pkg::coord_t xc_reg, yc_reg, wc_reg, hc_reg;
    rac_pkg::coord_t wl_reg, hl_reg;
    rac_pkg::coord_t wf_reg, hf_reg;
    rac_pkg::coord_t x_hi_reg, y_hi_reg;
    logic            ok_reg;
    logic [SETTLE_W-1:0] settle_reg;

    rac_pkg::coord_t x_end, y_end, wl_next, hl_next, w_abs, w_rem;

    // The pipeline recomputes every cycle; the settle counter marks when the
    // last stage again reflects the registers after a write.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write) begin
            settle_reg <= SETTLE_W'(rac_pkg::CLIP_STAGES);
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    always_comb begin
        x_end   = xc_reg + wc_reg;
        y_end   = yc_reg + hc_reg;
        wl_next = (x_end > sw_reg) ? (sw_reg - xc_reg) : wc_reg;
        hl_next = (y_end > sh_reg) ? (sh_reg - yc_reg) : hc_reg;
        // The remainder keeps the sign of the width, so the width is
        // truncated toward zero to a multiple of four.
        w_abs   = wl_reg[rac_pkg::COORD_W-1] ? -wl_reg : wl_reg;
        w_rem   = wl_reg[rac_pkg::COORD_W-1] ? -(w_abs & rac_pkg::coord_t'(3)) :
                  (w_abs & rac_pkg::coord_t'(3));
    end

    always_ff @(posedge aclk) begin
        xd_reg <= rac_pkg::coord_t'(cfg.region_x) - rac_pkg::coord_t'(cfg.capture_left);
        yd_reg <= rac_pkg::coord_t'(cfg.region_y) - rac_pkg::coord_t'(cfg.capture_top);
        sw_reg <= clamp_dim(cfg.screen_width);
        sh_reg <= clamp_dim(cfg.screen_height);

        xc_reg <= xd_reg[rac_pkg::COORD_W-1] ? '0 : xd_reg;
        yc_reg <= yd_reg[rac_pkg::COORD_W-1] ? '0 : yd_reg;
        wc_reg <= xd_reg[rac_pkg::COORD_W-1] ?
                  rac_pkg::coord_t'(cfg.region_width) + xd_reg :
                  rac_pkg::coord_t'(cfg.region_width);
        hc_reg <= yd_reg[rac_pkg::COORD_W-1] ?
                  rac_pkg::coord_t'(cfg.region_height) + yd_reg :
                  rac_pkg::coord_t'(cfg.region_height);

        wl_reg <= wl_next;
        hl_reg <= hl_next;

        wf_reg <= wl_reg - w_rem;
        hf_reg <= hl_reg;

        x_hi_reg <= xc_reg + wf_reg;
        y_hi_reg <= yc_reg + hf_reg;
        ok_reg   <= !(wf_reg[rac_pkg::COORD_W-1] || hf_reg[rac_pkg::COORD_W-1]);
    end

    assign clip.x_lo     = xc_reg;
    assign clip.x_hi     = x_hi_reg;
    assign clip.y_lo     = yc_reg;
    assign clip.y_hi     = y_hi_reg;
    assign clip.screen_w = sw_reg;
    assign clip.ok       = ok_reg;
    assign clip.settled  = (settle_reg == '0);

endmodule

// ----- src/rac_front.sv -----
// Front end: takes pixels, tracks the raster position and accumulates the
// region sums; hands each finished frame to the queue. Depends on rac_pkg.
module rac_front #(
    parameter int MAX_SCREEN_DIM = rac_pkg::MAX_SCREEN_DIM_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rac_pkg::clip_t               clip,
    input  rac_pkg::queue_status_t       q_status,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rac_pkg::COLOR_W-1:0]  s_pix_blue,
    input  logic [rac_pkg::COLOR_W-1:0]  s_pix_green,
    input  logic [rac_pkg::COLOR_W-1:0]  s_pix_red,
    input  logic                         s_frame_end,
    output logic                         push,
    output rac_pkg::frame_sum_t          push_data
);

    localparam int PW = $clog2(MAX_SCREEN_DIM);

    logic [PW-1:0]               col_reg, row_reg;
    logic [rac_pkg::SUM_W-1:0]   sum_red_reg, sum_green_reg, sum_blue_reg;
    logic [rac_pkg::COUNT_W-1:0] count_reg;

    logic [rac_pkg::SUM_W-1:0]   sum_red_next, sum_green_next, sum_blue_next;
    logic [rac_pkg::COUNT_W-1:0] count_next;
    logic [PW:0]                 col_inc;
    rac_pkg::coord_t             col_s, row_s;
    logic                        accept, in_region, col_wrap;

    assign s_ready = clip.settled && !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        col_s     = rac_pkg::coord_t'(col_reg);
        row_s     = rac_pkg::coord_t'(row_reg);
        in_region = clip.ok && (col_s >= clip.x_lo) && (col_s < clip.x_hi) &&
                    (row_s >= clip.y_lo) && (row_s < clip.y_hi);
        sum_red_next   = sum_red_reg   + (in_region ? rac_pkg::SUM_W'(s_pix_red)   : '0);
        sum_green_next = sum_green_reg + (in_region ? rac_pkg::SUM_W'(s_pix_green) : '0);
        sum_blue_next  = sum_blue_reg  + (in_region ? rac_pkg::SUM_W'(s_pix_blue)  : '0);
        count_next     = count_reg + rac_pkg::COUNT_W'(in_region);
        col_inc        = {1'b0, col_reg} + (PW + 1)'(1);
        col_wrap       = rac_pkg::coord_t'(col_inc) >= clip.screen_w;
    end

    // The last pixel of a frame is counted into the sums that are pushed.
    assign push                = accept && s_frame_end;
    assign push_data.sum_red   = sum_red_next;
    assign push_data.sum_green = sum_green_next;
    assign push_data.sum_blue  = sum_blue_next;
    assign push_data.count     = count_next;
    assign push_data.ok        = clip.ok;

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            col_reg       <= '0;
            row_reg       <= '0;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
            count_reg     <= '0;
        end else if (accept) begin
            sum_red_reg   <= sum_red_next;
            sum_green_reg <= sum_green_next;
            sum_blue_reg  <= sum_blue_next;
            count_reg     <= count_next;
            if (col_wrap) begin
                col_reg <= '0;
                row_reg <= (row_reg == PW'(MAX_SCREEN_DIM - 1)) ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_inc[PW-1:0];
            end
        end
    end

endmodule

// ----- src/rac_queue.sv -----
// Small queue of finished frame sums between the front and the back end.
// Depends on rac_pkg.
module rac_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  rac_pkg::frame_sum_t    push_data,
    input  logic                   pop,
    output rac_pkg::frame_sum_t    rd_data,
    output rac_pkg::queue_status_t status
);

    localparam int DEPTH = rac_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rac_pkg::frame_sum_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    fill_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assign rd_data      = entry_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == CNT_W'(DEPTH));
    assign status.empty = (fill_reg == '0);

endmodule

// ----- src/rac_back.sv -----
// Back end: three restoring divider lanes that share one step counter turn
// the frame sums into rounded means, then hold the result. Depends on rac_pkg.
module rac_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rac_pkg::queue_status_t       q_status,
    input  rac_pkg::frame_sum_t          rd_data,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rac_pkg::COLOR_W-1:0]  m_avg_red,
    output logic [rac_pkg::COLOR_W-1:0]  m_avg_green,
    output logic [rac_pkg::COLOR_W-1:0]  m_avg_blue,
    output logic                         m_region_empty
);

    localparam int LANES  = 3;
    localparam int NW     = rac_pkg::SUM_W + 2;      // 2*sum + count
    localparam int DW     = rac_pkg::COUNT_W + 1;    // 2*count
    localparam int STEP_W = $clog2(NW + 1);
    localparam int CW     = rac_pkg::COLOR_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     den_reg;
    logic              ok_reg, zero_reg;

    logic [NW-1:0]            num_reg [LANES];
    logic [DW-1:0]            rem_reg [LANES];
    logic [CW-1:0]            q_reg   [LANES];
    logic [DW:0]              trial   [LANES];
    logic                     take    [LANES];
    logic [rac_pkg::SUM_W-1:0] sum_in [LANES];

    assign sum_in[0] = rd_data.sum_red;
    assign sum_in[1] = rd_data.sum_green;
    assign sum_in[2] = rd_data.sum_blue;

    assign pop = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == STEP_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                step_reg <= STEP_W'(NW);
            end else if (state_reg == ST_DIV) begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            den_reg  <= {rd_data.count, 1'b0};
            ok_reg   <= rd_data.ok;
            zero_reg <= (rd_data.count == '0);
        end
    end

    // One quotient bit per step; only the low byte of the quotient is kept.
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        assign trial[i] = {rem_reg[i], num_reg[i][NW-1]};
        assign take[i]  = trial[i] >= {1'b0, den_reg};

        always_ff @(posedge aclk) begin
            if (pop) begin
                num_reg[i] <= {1'b0, sum_in[i], 1'b0} + NW'(rd_data.count);
                rem_reg[i] <= '0;
                q_reg[i]   <= '0;
            end else if (state_reg == ST_DIV) begin
                num_reg[i] <= {num_reg[i][NW-2:0], 1'b0};
                rem_reg[i] <= take[i] ? DW'(trial[i] - {1'b0, den_reg}) : trial[i][DW-1:0];
                q_reg[i]   <= {q_reg[i][CW-2:0], take[i]};
            end
        end
    end

    assign m_valid        = (state_reg == ST_OUT);
    assign m_avg_red      = (ok_reg && !zero_reg) ? q_reg[0] : '0;
    assign m_avg_green    = (ok_reg && !zero_reg) ? q_reg[1] : '0;
    assign m_avg_blue     = (ok_reg && !zero_reg) ? q_reg[2] : '0;
    assign m_region_empty = !ok_reg;

endmodule
